// ===== rtl/rrst_pkg.sv =====
// ----------------------------------------------------------------------------
// rrst_pkg
// Shared constants, types and the command and status structs for the round-robin timer.
// ----------------------------------------------------------------------------
package rrst_pkg;

   localparam int MaxProcsDefault = 16;
   localparam int TimeWidth       = 21;
   localparam int ValueWidth      = 16;
   localparam int IndexWidth      = 4;
   localparam logic [ValueWidth-1:0] QuantumReset = 16'd4;

   typedef enum logic [5:0] {
      ST_LOAD  = 6'b000001,
      ST_SORT  = 6'b000010,
      ST_VISIT = 6'b000100,
      ST_SCAN  = 6'b001000,
      ST_EMIT  = 6'b010000,
      ST_CLEAR = 6'b100000
   } state_type;

   typedef struct packed {
      logic load;
      logic sort_step;
      logic sim_start;
      logic visit;
      logic scan_start;
      logic scan_step;
      logic emit_start;
      logic emit_step;
      logic clear;
   } cmd_type;

   typedef struct packed {
      logic sort_done;
      logic visit_ready;
      logic all_done;
      logic scan_done;
      logic emit_last;
      logic empty;
   } status_type;

endpackage

// ===== rtl/rrst_if.sv =====
// ----------------------------------------------------------------------------
// rrst_req_if / rrst_rsp_if
// Valid/ready channels for job items and result items.
// ----------------------------------------------------------------------------
interface rrst_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] arrival_time;
   logic [15:0] burst_time;
   logic        is_last;
   modport source (output valid, arrival_time, burst_time, is_last, input ready);
   modport sink   (input valid, arrival_time, burst_time, is_last, output ready);
endinterface

interface rrst_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  job_index;
   logic [20:0] first_start;
   logic [20:0] completion_time;
   logic [20:0] waiting_time;
   logic [20:0] turnaround_time;
   logic        last_result;
   modport source (output valid, job_index, first_start, completion_time,
                   waiting_time, turnaround_time, last_result, input ready);
   modport sink   (input valid, job_index, first_start, completion_time,
                   waiting_time, turnaround_time, last_result, output ready);
endinterface

// ===== rtl/round_robin_schedule_timing.sv =====
// A job item is loaded, then shifted past each later-arriving sorted slot.
// After the last item, each service turn is one visit and each idle visit a
// scan of the job table; results then leave one per cycle while rsp.ready holds.
// A new job item is taken only after the previous one has been inserted.
// Reset is synchronous and active high; quantum returns to 4.
// ----------------------------------------------------------------------------
// round_robin_schedule_timing
// Round-robin scheduling timer: loads jobs, sorts them, reports timings.
// ----------------------------------------------------------------------------
module round_robin_schedule_timing #(
   parameter int MaxProcs = rrst_pkg::MaxProcsDefault
) (
   input  logic         clock,
   input  logic         reset,
   rrst_req_if.sink     req,
   rrst_rsp_if.source   rsp,
   input  logic         csr_write_enable,
   input  logic [15:0]  csr_write_data
);

   rrst_pkg::cmd_type    cmd;
   rrst_pkg::status_type status;
   logic [15:0] quantum_ff;
   logic        last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         quantum_ff <= rrst_pkg::QuantumReset;
         last_ff    <= 1'b0;
      end else begin
         if (csr_write_enable) quantum_ff <= csr_write_data;
         if (cmd.load) last_ff <= req.is_last;
      end
   end

   rrst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_last  (last_ff),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .status    (status),
      .cmd       (cmd)
   );

   rrst_datapath #(.MaxProcs(MaxProcs)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .quantum    (quantum_ff),
      .in_arrival (req.arrival_time),
      .in_burst   (req.burst_time),
      .rsp_valid  (rsp.valid),
      .rsp_index  (rsp.job_index),
      .rsp_start  (rsp.first_start),
      .rsp_finish (rsp.completion_time),
      .rsp_wait   (rsp.waiting_time),
      .rsp_turn   (rsp.turnaround_time),
      .rsp_last   (rsp.last_result)
   );

endmodule

// ===== rtl/rrst_ctrl.sv =====
// ----------------------------------------------------------------------------
// rrst_ctrl
// Sequencer: load, insertion sort, round-robin visits, scans, result output.
// ----------------------------------------------------------------------------
module rrst_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_last,
   output logic                  req_ready,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  rrst_pkg::status_type  status,
   output rrst_pkg::cmd_type     cmd
);

   rrst_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrst_pkg::ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == rrst_pkg::ST_LOAD);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         rrst_pkg::ST_LOAD: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = rrst_pkg::ST_SORT;
            end
         end
         rrst_pkg::ST_SORT: begin
            if (status.sort_done) begin
               // The load that entered sorting may have closed the set.
               if (req_last) begin
                  cmd.sim_start = 1'b1;
                  state_in = rrst_pkg::ST_VISIT;
               end else begin
                  state_in = rrst_pkg::ST_LOAD;
               end
            end else begin
               cmd.sort_step = 1'b1;
            end
         end
         rrst_pkg::ST_VISIT: begin
            if (status.empty) begin
               state_in = rrst_pkg::ST_CLEAR;
            end else if (status.all_done) begin
               cmd.emit_start = 1'b1;
               state_in = rrst_pkg::ST_EMIT;
            end else if (status.visit_ready) begin
               cmd.visit = 1'b1;
            end else begin
               cmd.scan_start = 1'b1;
               state_in = rrst_pkg::ST_SCAN;
            end
         end
         rrst_pkg::ST_SCAN: begin
            if (status.scan_done) begin
               state_in = rrst_pkg::ST_VISIT;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         rrst_pkg::ST_EMIT: begin
            if (rsp_valid && rsp_ready) begin
               if (status.emit_last) begin
                  // Clearing here drops the result valid with the last item.
                  cmd.clear = 1'b1;
                  state_in  = rrst_pkg::ST_LOAD;
               end else begin
                  cmd.emit_step = 1'b1;
               end
            end
         end
         rrst_pkg::ST_CLEAR: begin
            cmd.clear = 1'b1;
            state_in  = rrst_pkg::ST_LOAD;
         end
         default: begin
            state_in = rrst_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

// ===== rtl/rrst_datapath.sv =====
// ----------------------------------------------------------------------------
// rrst_datapath
// Job tables, sort shifter, service arithmetic and arrival scan.
// ----------------------------------------------------------------------------
module rrst_datapath #(
   parameter int MaxProcs = rrst_pkg::MaxProcsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  rrst_pkg::cmd_type     cmd,
   output rrst_pkg::status_type  status,
   input  logic [15:0]           quantum,
   input  logic [15:0]           in_arrival,
   input  logic [15:0]           in_burst,
   output logic                  rsp_valid,
   output logic [3:0]            rsp_index,
   output logic [20:0]           rsp_start,
   output logic [20:0]           rsp_finish,
   output logic [20:0]           rsp_wait,
   output logic [20:0]           rsp_turn,
   output logic                  rsp_last
);

   localparam int PW = (MaxProcs > 1) ? $clog2(MaxProcs) : 1;
   localparam int CW = $clog2(MaxProcs + 1);
   localparam int TW = rrst_pkg::TimeWidth;

   logic [15:0]   arr_ff [MaxProcs];
   logic [15:0]   rem_ff [MaxProcs];
   logic [3:0]    org_ff [MaxProcs];
   logic [TW-1:0] start_ff [MaxProcs];
   logic [TW-1:0] fin_ff [MaxProcs];
   logic [TW-1:0] wait_ff [MaxProcs];
   logic [MaxProcs-1:0] started_ff, done_ff;

   logic [CW-1:0] count_ff, finished_ff;
   logic [PW-1:0] pos_ff, ptr_ff, scan_ff, emit_ff;
   logic          ins_ff, ready_seen_ff, have_min_ff, scan_end_ff;
   logic [15:0]   min_ff;
   logic [15:0]   new_arr_ff, new_bur_ff;
   logic [3:0]    new_org_ff;
   logic [TW-1:0] time_ff;
   logic          rsp_valid_ff;

   logic [15:0]   q;
   logic [PW-1:0] prev;
   logic [PW-1:0] ptr_next;
   logic [15:0]   rem_p, arr_p;
   logic [TW-1:0] run;
   logic [TW-1:0] time_next;
   logic [15:0]   arr_s;

   assign q     = (quantum == 16'd0) ? 16'd1 : quantum;
   assign prev  = pos_ff - PW'(1);
   assign rem_p = rem_ff[ptr_ff];
   assign arr_p = arr_ff[ptr_ff];
   assign run   = (rem_p < q) ? TW'(rem_p) : TW'(q);
   assign time_next = time_ff + run;
   assign ptr_next  = (CW'(ptr_ff) + CW'(1) >= count_ff) ? '0 : ptr_ff + PW'(1);
   assign arr_s     = arr_ff[scan_ff];

   // Sort ends when the insertion slot is found or no insertion is pending.
   assign status.sort_done   = !ins_ff || pos_ff == '0 || !(arr_ff[prev] > new_arr_ff);
   assign status.visit_ready = !done_ff[ptr_ff] && TW'(arr_p) <= time_ff;
   assign status.all_done    = finished_ff == count_ff;
   assign status.scan_done   = scan_end_ff;
   assign status.emit_last   = CW'(emit_ff) + CW'(1) == count_ff;
   assign status.empty       = count_ff == '0;

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         count_ff     <= '0;
         finished_ff  <= '0;
         started_ff   <= '0;
         done_ff      <= '0;
         time_ff      <= '0;
         ptr_ff       <= '0;
         ins_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_end_ff  <= 1'b0;
      end else begin
         if (cmd.load) begin
            ins_ff     <= count_ff < CW'(MaxProcs);
            pos_ff     <= count_ff[PW-1:0];
            new_arr_ff <= in_arrival;
            new_bur_ff <= in_burst;
            new_org_ff <= 4'(count_ff);
         end
         if (cmd.sort_step) begin
            arr_ff[pos_ff] <= arr_ff[prev];
            rem_ff[pos_ff] <= rem_ff[prev];
            org_ff[pos_ff] <= org_ff[prev];
            pos_ff <= prev;
         end else if (!cmd.load && ins_ff && status.sort_done) begin
            arr_ff[pos_ff] <= new_arr_ff;
            rem_ff[pos_ff] <= new_bur_ff;
            org_ff[pos_ff] <= new_org_ff;
            count_ff <= count_ff + CW'(1);
            ins_ff   <= 1'b0;
         end
         if (cmd.visit) begin
            if (!started_ff[ptr_ff]) begin
               started_ff[ptr_ff] <= 1'b1;
               start_ff[ptr_ff]   <= time_ff;
               wait_ff[ptr_ff]    <= time_ff - TW'(arr_p);
            end else begin
               wait_ff[ptr_ff] <= wait_ff[ptr_ff] + (time_ff - fin_ff[ptr_ff]);
            end
            rem_ff[ptr_ff] <= rem_p - 16'(run);
            fin_ff[ptr_ff] <= time_next;
            time_ff        <= time_next;
            if (rem_p <= q) begin
               done_ff[ptr_ff] <= 1'b1;
               finished_ff     <= finished_ff + CW'(1);
            end
            ptr_ff <= ptr_next;
         end
         // Scan the unfinished jobs for readiness and the earliest arrival.
         if (cmd.scan_start) begin
            scan_ff       <= '0;
            ready_seen_ff <= 1'b0;
            have_min_ff   <= 1'b0;
            scan_end_ff   <= 1'b0;
         end
         if (cmd.scan_step) begin
            if (!done_ff[scan_ff]) begin
               if (TW'(arr_s) <= time_ff) ready_seen_ff <= 1'b1;
               if (!have_min_ff || arr_s < min_ff) begin
                  min_ff      <= arr_s;
                  have_min_ff <= 1'b1;
               end
            end
            if (CW'(scan_ff) + CW'(1) >= count_ff) begin
               scan_end_ff <= 1'b1;
            end else begin
               scan_ff <= scan_ff + PW'(1);
            end
         end
         if (scan_end_ff) begin
            scan_end_ff <= 1'b0;
            if (ready_seen_ff) ptr_ff <= ptr_next;
            else               time_ff <= TW'(min_ff);
         end
         if (cmd.emit_start) begin
            emit_ff      <= '0;
            rsp_valid_ff <= 1'b1;
         end
         if (cmd.emit_step) emit_ff <= emit_ff + PW'(1);
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_index  = org_ff[emit_ff];
   assign rsp_start  = start_ff[emit_ff];
   assign rsp_finish = fin_ff[emit_ff];
   assign rsp_wait   = wait_ff[emit_ff];
   assign rsp_turn   = fin_ff[emit_ff] - TW'(arr_ff[emit_ff]);
   assign rsp_last   = status.emit_last;

endmodule
